>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// clocked on clk, disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge
`define TQCR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tqcr check failed");

// condition in one cycle implies consequence in the next
`define TQCR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) ante |=> cons) \
    else $error("tqcr check failed");

`endif

>>> src/tqcr_pkg.sv
// ----------------------------------------------------------------------------
// tqcr_pkg
// widths, codes and helpers for the 2q replacement block
// ----------------------------------------------------------------------------
`default_nettype none

package tqcr_pkg;

  localparam int MAX_RESIDENT = 1024;
  localparam int MAX_GHOST    = 1024;
  localparam int POOL         = MAX_RESIDENT + MAX_GHOST;
  localparam int IDX_W        = $clog2(POOL);
  localparam int LNK_W        = IDX_W + 1;   // msb set means no entry
  localparam int LEN_W        = LNK_W;
  localparam int CFG_W        = 11;
  localparam int CIDX_W       = 2;
  localparam int KEY_W        = 64;
  localparam int HALF_W       = 32;
  localparam int META_W       = 4;

  localparam logic [LNK_W-1:0] NIL = LNK_W'(POOL);

  // meta layout: [0] valid, [2:1] queue, [3] prefetched
  localparam int M_V  = 0;
  localparam int M_PF = 3;

  localparam logic [1:0] Q_A1 = 2'd0;
  localparam logic [1:0] Q_AM = 2'd1;
  localparam logic [1:0] Q_GH = 2'd2;

  localparam logic [CIDX_W-1:0] REG_CAPACITY = 2'd0;
  localparam logic [CIDX_W-1:0] REG_A1_LIMIT = 2'd1;
  localparam logic [CIDX_W-1:0] REG_GHOST    = 2'd2;

  function automatic logic [1:0] queue_of(input logic [META_W-1:0] m);
    logic [1:0] q;
    q = m[2:1];
    return (q == 2'd3) ? Q_GH : q;
  endfunction

  function automatic logic [META_W-1:0] mk_meta(input logic pf, input logic [1:0] q);
    return {pf, q, 1'b1};
  endfunction

endpackage

`default_nettype wire

>>> src/tqcr_ifs.sv
// ----------------------------------------------------------------------------
// tqcr channel interfaces
// request, response and register write channels, valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface tqcr_req_if;
  import tqcr_pkg::*;
  logic              valid;
  logic              ready;
  logic              func;
  logic [HALF_W-1:0] file_id;
  logic [HALF_W-1:0] block_number;
  logic              is_prefetch;
  logic              group_ready;
  modport source (output valid, func, file_id, block_number, is_prefetch, group_ready,
                  input ready);
  modport sink   (input valid, func, file_id, block_number, is_prefetch, group_ready,
                  output ready);
endinterface

interface tqcr_rsp_if;
  logic valid;
  logic ready;
  logic was_hit;
  logic resident;
  logic counted_hit;
  logic counted_miss;
  logic prefetch_hit;
  logic ghost_hit;
  modport source (output valid, was_hit, resident, counted_hit, counted_miss,
                  prefetch_hit, ghost_hit, input ready);
  modport sink   (input valid, was_hit, resident, counted_hit, counted_miss,
                  prefetch_hit, ghost_hit, output ready);
endinterface

interface tqcr_cfg_if;
  import tqcr_pkg::*;
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] index;
  logic [CFG_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/two_queue_cache_replacement.sv
// ----------------------------------------------------------------------------
// two_queue_cache_replacement
// 2q buffer cache policy with prefetch awareness, one reference at a time
// ----------------------------------------------------------------------------
// req carries one word per reference: func (0 reference, 1 probe), the key
// file_id/block_number, is_prefetch and group_ready. rsp returns one word
// per request with the hit/miss flags. cfg writes cache_capacity (0),
// a1_limit (1) and ghost_capacity (2); it is always ready and is meant to be
// used while no request is in flight.
// The entry pool is searched linearly through the key and meta memories,
// one entry per cycle up to the fill mark (the highest slot ever used) or
// the first match; dispatch follows, then linked-list updates, each step
// reading or writing entries of the link memories under the sequencer,
// then the response word is offered. req is ready only when idle.
// rsp holds its word until taken; a stalled receiver stalls the block.
// Reset empties all queues and the fill mark at once, no clearing pass, and
// loads the register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module two_queue_cache_replacement (
  input  logic       clk,
  input  logic       rst,
  tqcr_req_if.sink   req,
  tqcr_rsp_if.source rsp,
  tqcr_cfg_if.sink   cfg
);
  import tqcr_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;
  localparam logic [3:0] S_DISP   = 4'd2;
  localparam logic [3:0] S_UL_RD  = 4'd3;
  localparam logic [3:0] S_UL_WR  = 4'd4;
  localparam logic [3:0] S_PU_A   = 4'd5;
  localparam logic [3:0] S_PU_B   = 4'd6;
  localparam logic [3:0] S_H_PUSH = 4'd7;
  localparam logic [3:0] S_MR     = 4'd8;
  localparam logic [3:0] S_MR_A1  = 4'd9;
  localparam logic [3:0] S_MR_A1G = 4'd10;
  localparam logic [3:0] S_MR_GD  = 4'd11;
  localparam logic [3:0] S_MR_END = 4'd12;
  localparam logic [3:0] S_OUT    = 4'd13;

  logic [3:0] state;
  logic [3:0] ret;

  // entry memories
  logic [KEY_W-1:0]  key_mem  [POOL];
  logic [META_W-1:0] meta_mem [POOL];
  logic [LNK_W-1:0]  prev_mem [POOL];
  logic [LNK_W-1:0]  next_mem [POOL];
  logic [KEY_W-1:0]  rd_key;
  logic [META_W-1:0] rd_meta;
  logic [LNK_W-1:0]  rd_prev;
  logic [LNK_W-1:0]  rd_next;
  logic [IDX_W-1:0]  raddr;

  logic              key_we, meta_we, prev_we, next_we;
  logic [IDX_W-1:0]  key_wa, meta_wa, prev_wa, next_wa;
  logic [KEY_W-1:0]  key_wd;
  logic [META_W-1:0] meta_wd;
  logic [LNK_W-1:0]  prev_wd, next_wd;

  // request
  logic [KEY_W-1:0] cur_key;
  logic             cur_func, cur_pf, cur_gr;

  // search
  logic [LNK_W-1:0]  scnt;
  logic [LNK_W-1:0]  hw;
  logic              pvalid;
  logic [IDX_W-1:0]  pidx;
  logic              found;
  logic [IDX_W-1:0]  b;
  logic [META_W-1:0] bmeta;
  logic              free_found;
  logic [IDX_W-1:0]  free_idx;

  // queues
  logic [LNK_W-1:0] head [3];
  logic [LNK_W-1:0] tail [3];
  logic [LEN_W-1:0] qlen [3];
  logic [IDX_W-1:0] alloc;

  // registers
  logic [CFG_W-1:0] cap, a1lim, gcap;

  // sequencer operands
  logic [IDX_W-1:0]  tgt;
  logic [1:0]        pq;
  logic [META_W-1:0] pmeta;
  logic [LNK_W-1:0]  oldh;
  logic [META_W-1:0] rmeta;
  logic              ghost_mode;
  logic [IDX_W-1:0]  slot, disc;
  logic              slot_ok, disc_ok;

  logic o_hit, o_res, o_chit, o_cmiss, o_phit, o_ghit;

  logic [CFG_W-1:0] cap_eff, gcap_eff;
  logic [1:0]       ul_q, bq;
  logic             free_ok;
  logic [IDX_W-1:0] free_sel;

  assign cap_eff  = (cap == '0) ? CFG_W'(1) :
                    (cap > CFG_W'(MAX_RESIDENT)) ? CFG_W'(MAX_RESIDENT) : cap;
  assign gcap_eff = (gcap > CFG_W'(MAX_GHOST)) ? CFG_W'(MAX_GHOST) : gcap;
  assign ul_q     = queue_of(rd_meta);
  assign bq       = queue_of(bmeta);
  assign free_ok  = free_found || !hw[LNK_W-1];
  assign free_sel = free_found ? free_idx : hw[IDX_W-1:0];

  assign raddr = (state == S_SCAN) ? scnt[IDX_W-1:0] : tgt;

  assign req.ready        = (state == S_IDLE);
  assign cfg.ready        = 1'b1;
  assign rsp.valid        = (state == S_OUT);
  assign rsp.was_hit      = o_hit;
  assign rsp.resident     = o_res;
  assign rsp.counted_hit  = o_chit;
  assign rsp.counted_miss = o_cmiss;
  assign rsp.prefetch_hit = o_phit;
  assign rsp.ghost_hit    = o_ghit;

  always_ff @(posedge clk) begin
    if (key_we) key_mem[key_wa] <= key_wd;
    rd_key <= key_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[meta_wa] <= meta_wd;
    rd_meta <= meta_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    rd_prev <= prev_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    rd_next <= next_mem[raddr];
  end

  // memory write ports
  always_comb begin
    key_we  = 1'b0; key_wa  = slot;  key_wd  = cur_key;
    meta_we = 1'b0; meta_wa = tgt;   meta_wd = '0;
    prev_we = 1'b0; prev_wa = tgt;   prev_wd = NIL;
    next_we = 1'b0; next_wa = tgt;   next_wd = NIL;
    case (state)
      S_DISP: begin
        if (!cur_func && found && bq == Q_A1 && bmeta[M_PF]) begin
          meta_we = 1'b1;
          meta_wa = b;
          meta_wd = mk_meta(1'b0, Q_A1);
        end
      end
      S_UL_WR: begin
        if (!rd_prev[LNK_W-1]) begin
          next_we = 1'b1;
          next_wa = rd_prev[IDX_W-1:0];
          next_wd = rd_next;
        end
        if (!rd_next[LNK_W-1]) begin
          prev_we = 1'b1;
          prev_wa = rd_next[IDX_W-1:0];
          prev_wd = rd_prev;
        end
      end
      S_PU_A: begin
        prev_we = 1'b1;
        next_we = 1'b1;
        next_wd = head[pq];
        meta_we = 1'b1;
        meta_wd = pmeta;
      end
      S_PU_B: begin
        if (!oldh[LNK_W-1]) begin
          prev_we = 1'b1;
          prev_wa = oldh[IDX_W-1:0];
          prev_wd = {1'b0, tgt};
        end
      end
      S_MR_A1: meta_we = rmeta[M_PF];
      S_MR_GD: meta_we = 1'b1;
      S_MR_END: key_we = !ghost_mode && slot_ok;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      hw      <= '0;
      head[0] <= NIL; head[1] <= NIL; head[2] <= NIL;
      tail[0] <= NIL; tail[1] <= NIL; tail[2] <= NIL;
      qlen[0] <= '0;  qlen[1] <= '0;  qlen[2] <= '0;
      alloc   <= '0;
      pvalid  <= 1'b0;
      cap     <= CFG_W'(1024);
      a1lim   <= CFG_W'(256);
      gcap    <= CFG_W'(512);
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          REG_CAPACITY: cap   <= cfg.data;
          REG_A1_LIMIT: a1lim <= cfg.data;
          REG_GHOST:    gcap  <= cfg.data;
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (req.valid) begin
            cur_key    <= {req.file_id, req.block_number};
            cur_func   <= req.func;
            cur_pf     <= req.is_prefetch;
            cur_gr     <= req.group_ready;
            scnt       <= '0;
            pvalid     <= 1'b0;
            found      <= 1'b0;
            free_found <= 1'b0;
            state      <= S_SCAN;
          end
        end

        S_SCAN: begin
          if (pvalid && rd_meta[M_V] && rd_key == cur_key) begin
            found  <= 1'b1;
            b      <= pidx;
            bmeta  <= rd_meta;
            pvalid <= 1'b0;
            state  <= S_DISP;
          end else begin
            if (pvalid && !rd_meta[M_V] && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= pidx;
            end
            if (scnt < hw) begin
              pidx   <= scnt[IDX_W-1:0];
              scnt   <= scnt + LNK_W'(1);
              pvalid <= 1'b1;
            end else begin
              pvalid <= 1'b0;
            end
            if (!pvalid && scnt >= hw) state <= S_DISP;
          end
        end

        S_DISP: begin
          o_hit      <= 1'b0;
          o_res      <= 1'b0;
          o_chit     <= 1'b0;
          o_cmiss    <= 1'b0;
          o_phit     <= 1'b0;
          o_ghit     <= 1'b0;
          ghost_mode <= 1'b0;
          slot_ok    <= 1'b0;
          disc_ok    <= 1'b0;
          if (cur_func) begin
            o_res <= found && bq != Q_GH;
            state <= S_OUT;
          end else if (found && bq != Q_GH) begin
            o_hit <= 1'b1;
            if (bmeta[M_PF]) begin
              o_chit  <= cur_gr;
              o_phit  <= cur_gr;
              o_cmiss <= !cur_gr;
            end else begin
              o_chit <= 1'b1;
            end
            if (bq == Q_AM) begin
              tgt   <= b;
              pmeta <= mk_meta(1'b0, Q_AM);
              pq    <= Q_AM;
              ret   <= S_H_PUSH;
              state <= S_UL_RD;
            end else begin
              state <= S_OUT;
            end
          end else if (found) begin
            // ghost entry comes back into am
            o_cmiss    <= !cur_pf;
            o_ghit     <= !cur_pf;
            ghost_mode <= 1'b1;
            tgt        <= b;
            ret        <= S_MR;
            state      <= S_UL_RD;
          end else begin
            o_cmiss <= !cur_pf;
            state   <= S_MR;
          end
        end

        S_UL_RD: state <= S_UL_WR;

        S_UL_WR: begin
          if (rd_prev[LNK_W-1]) head[ul_q] <= rd_next;
          if (rd_next[LNK_W-1]) tail[ul_q] <= rd_prev;
          if (qlen[ul_q] != '0) qlen[ul_q] <= qlen[ul_q] - LEN_W'(1);
          rmeta <= rd_meta;
          state <= ret;
        end

        S_PU_A: begin
          oldh <= head[pq];
          if (head[pq][LNK_W-1]) tail[pq] <= {1'b0, tgt};
          head[pq] <= {1'b0, tgt};
          qlen[pq] <= qlen[pq] + LEN_W'(1);
          state    <= S_PU_B;
        end

        S_PU_B: state <= ret;

        S_H_PUSH: begin
          ret   <= S_OUT;
          state <= S_PU_A;
        end

        S_MR: begin
          if (alloc < IDX_W'(cap_eff)) begin
            alloc   <= alloc + IDX_W'(1);
            slot    <= free_sel;
            slot_ok <= free_ok;
            state   <= S_MR_END;
          end else if ((qlen[Q_A1] > LEN_W'(a1lim) || qlen[Q_AM] == '0) &&
                       qlen[Q_A1] != '0) begin
            tgt   <= tail[Q_A1][IDX_W-1:0];
            ret   <= S_MR_A1;
            state <= S_UL_RD;
          end else if (qlen[Q_AM] != '0) begin
            tgt   <= tail[Q_AM][IDX_W-1:0];
            ret   <= S_MR_GD;
            state <= S_UL_RD;
          end else begin
            slot    <= free_sel;
            slot_ok <= free_ok;
            state   <= S_MR_END;
          end
        end

        S_MR_A1: begin
          // unused prefetched entries are dropped, others become ghosts
          if (rmeta[M_PF]) begin
            disc    <= tgt;
            disc_ok <= 1'b1;
            state   <= S_MR_A1G;
          end else begin
            pmeta <= mk_meta(1'b0, Q_GH);
            pq    <= Q_GH;
            ret   <= S_MR_A1G;
            state <= S_PU_A;
          end
        end

        S_MR_A1G: begin
          if (ghost_mode) begin
            state <= S_MR_END;
          end else if (qlen[Q_GH] > LEN_W'(gcap_eff)) begin
            tgt   <= tail[Q_GH][IDX_W-1:0];
            ret   <= S_MR_GD;
            state <= S_UL_RD;
          end else begin
            slot    <= free_ok ? free_sel : disc;
            slot_ok <= free_ok || disc_ok;
            state   <= S_MR_END;
          end
        end

        S_MR_GD: begin
          slot    <= tgt;
          slot_ok <= 1'b1;
          state   <= S_MR_END;
        end

        S_MR_END: begin
          if (ghost_mode) begin
            tgt   <= b;
            pmeta <= mk_meta(cur_pf, Q_AM);
            pq    <= Q_AM;
            ret   <= S_OUT;
            state <= S_PU_A;
          end else if (slot_ok) begin
            tgt   <= slot;
            pmeta <= mk_meta(cur_pf, Q_A1);
            pq    <= Q_A1;
            ret   <= S_OUT;
            state <= S_PU_A;
            if (LNK_W'(slot) >= hw) hw <= LNK_W'(slot) + LNK_W'(1);
          end else begin
            state <= S_OUT;
          end
        end

        S_OUT: begin
          if (rsp.ready) state <= S_IDLE;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/tqcr_checker.sv
// ----------------------------------------------------------------------------
// tqcr_checker
// port level checks for the 2q replacement block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tqcr_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_ready,
  input wire logic rsp_valid,
  input wire logic rsp_ready,
  input wire logic was_hit,
  input wire logic resident,
  input wire logic counted_hit,
  input wire logic counted_miss,
  input wire logic prefetch_hit,
  input wire logic ghost_hit
);

  // response word held until taken
  `TQCR_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid)

  // one request at a time
  `TQCR_ASSERT(a_no_accept_busy, rsp_valid |-> !req_ready)
  `TQCR_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)

  `TQCR_ASSERT(a_hit_or_miss, rsp_valid |-> !(counted_hit && counted_miss))

  // a resident probe answer carries nothing else
  `TQCR_ASSERT(a_probe_only, rsp_valid && resident |-> !(was_hit || counted_hit || counted_miss || prefetch_hit || ghost_hit))

endmodule

bind two_queue_cache_replacement tqcr_checker u_tqcr_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .was_hit      (rsp.was_hit),
  .resident     (rsp.resident),
  .counted_hit  (rsp.counted_hit),
  .counted_miss (rsp.counted_miss),
  .prefetch_hit (rsp.prefetch_hit),
  .ghost_hit    (rsp.ghost_hit)
);

`default_nettype wire
